// ===== rtl/erob_pkg.sv =====
// Shared types and constants for the echo ranging obstacle avoider.
package erob_pkg;

    localparam int REG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PINS_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TICKS     = 3'd4;

    localparam logic [REG_W-1:0] RST_TRIGGER_TICKS  = 24'd160;
    localparam logic [REG_W-1:0] RST_NEAR_THRESHOLD = 24'd6531;
    localparam logic [REG_W-1:0] RST_STOP_TICKS     = 24'd4000000;
    localparam logic [REG_W-1:0] RST_BACK_TICKS     = 24'd4000000;
    localparam logic [REG_W-1:0] RST_TURN_TICKS     = 24'd8000000;

    localparam logic [1:0] DRV_STOP     = 2'd0;
    localparam logic [1:0] DRV_FORWARD  = 2'd1;
    localparam logic [1:0] DRV_BACKWARD = 2'd2;
    localparam logic [1:0] DRV_RIGHT    = 2'd3;

    localparam logic [PINS_W-1:0] PINS_STOP     = 4'd0;
    localparam logic [PINS_W-1:0] PINS_FORWARD  = 4'd10;
    localparam logic [PINS_W-1:0] PINS_BACKWARD = 4'd5;
    localparam logic [PINS_W-1:0] PINS_RIGHT    = 4'd6;

    typedef struct packed {
        logic [REG_W-1:0] trigger_ticks;
        logic [REG_W-1:0] near_threshold;
        logic [REG_W-1:0] stop_ticks;
        logic [REG_W-1:0] back_ticks;
        logic [REG_W-1:0] turn_ticks;
    } t_cfg;

    typedef struct packed {
        logic              trigger_out;
        logic [PINS_W-1:0] bridge_pins;
        logic [REG_W-1:0]  last_echo_ticks;
        logic              obstacle_seen;
    } t_result;

    function automatic logic [PINS_W-1:0] drive_pins(input logic [1:0] code);
        logic [PINS_W-1:0] pins;
        unique case (code)
            DRV_FORWARD:  pins = PINS_FORWARD;
            DRV_BACKWARD: pins = PINS_BACKWARD;
            DRV_RIGHT:    pins = PINS_RIGHT;
            default:      pins = PINS_STOP;
        endcase
        return pins;
    endfunction

endpackage

// ===== rtl/erob_cfg.sv =====
// Configuration register file for the echo ranging obstacle avoider.
module erob_cfg
    import erob_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [REG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks  <= RST_TRIGGER_TICKS;
            r_cfg.near_threshold <= RST_NEAR_THRESHOLD;
            r_cfg.stop_ticks     <= RST_STOP_TICKS;
            r_cfg.back_ticks     <= RST_BACK_TICKS;
            r_cfg.turn_ticks     <= RST_TURN_TICKS;
        end else if (i_wr) begin
            unique case (i_index)
                REG_TRIGGER_TICKS:  r_cfg.trigger_ticks  <= i_data;
                REG_NEAR_THRESHOLD: r_cfg.near_threshold <= i_data;
                REG_STOP_TICKS:     r_cfg.stop_ticks     <= i_data;
                REG_BACK_TICKS:     r_cfg.back_ticks     <= i_data;
                REG_TURN_TICKS:     r_cfg.turn_ticks     <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/erob_core.sv =====
// Phase sequencer, tick timers and echo counter of the obstacle avoider.
module erob_core
    import erob_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_echo_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CNT_W = (TIMER_BITS < REG_W) ? TIMER_BITS : REG_W;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [2:0] PH_TRIGGER = 3'd0;
    localparam logic [2:0] PH_MEASURE = 3'd1;
    localparam logic [2:0] PH_STOP    = 3'd2;
    localparam logic [2:0] PH_BACK    = 3'd3;
    localparam logic [2:0] PH_TURN    = 3'd4;

    logic [2:0]       r_phase,   n_phase;
    logic [REG_W-1:0] r_timer,   n_timer;
    logic [CNT_W-1:0] r_counter, n_counter;
    logic             r_prev,    n_prev;
    logic [1:0]       r_drive,   n_drive;
    logic             r_near,    n_near;
    logic [REG_W-1:0] r_last,    n_last;

    logic [REG_W-1:0] len;
    logic [REG_W-1:0] lim;
    logic [REG_W-1:0] timer_base;
    logic [REG_W-1:0] timer_inc;
    logic             done;
    logic [REG_W-1:0] count_ext;
    logic             trig;

    assign count_ext = REG_W'(r_counter);

    always_comb begin
        unique case (r_phase)
            PH_STOP: len = i_cfg.stop_ticks;
            PH_BACK: len = i_cfg.back_ticks;
            PH_TURN: len = i_cfg.turn_ticks;
            default: len = i_cfg.trigger_ticks;
        endcase
        lim = (len == '0) ? REG_W'(1) : len;
        if (r_phase == PH_TRIGGER || r_phase == PH_STOP || r_phase == PH_BACK ||
            r_phase == PH_TURN) begin
            timer_base = r_timer;
        end else begin
            timer_base = '0;
        end
        timer_inc = timer_base + REG_W'(1);
        done      = (timer_inc >= lim);
    end

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_counter = r_counter;
        n_drive   = r_drive;
        n_near    = r_near;
        n_last    = r_last;
        n_prev    = i_echo_level;
        trig      = 1'b0;
        unique case (r_phase)
            PH_MEASURE: begin
                if (r_prev && !i_echo_level) begin
                    n_last  = count_ext;
                    n_near  = (count_ext < i_cfg.near_threshold);
                    n_timer = '0;
                    if (count_ext < i_cfg.near_threshold) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_drive = DRV_FORWARD;
                        n_phase = PH_TRIGGER;
                    end
                end else if (r_counter != CNT_MAX) begin
                    n_counter = r_counter + CNT_W'(1);
                end
            end
            PH_STOP: begin
                n_drive = DRV_STOP;
                n_timer = done ? '0 : timer_inc;
                if (done) begin
                    n_phase = PH_BACK;
                end
            end
            PH_BACK: begin
                n_drive = DRV_BACKWARD;
                n_timer = done ? '0 : timer_inc;
                if (done) begin
                    n_phase = PH_TURN;
                end
            end
            PH_TURN: begin
                n_drive = DRV_RIGHT;
                n_timer = done ? '0 : timer_inc;
                if (done) begin
                    n_phase = PH_TRIGGER;
                end
            end
            default: begin
                trig    = 1'b1;
                n_timer = done ? '0 : timer_inc;
                if (done) begin
                    n_phase   = PH_MEASURE;
                    n_counter = '0;
                end else begin
                    n_phase = PH_TRIGGER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TRIGGER;
            r_timer   <= '0;
            r_counter <= '0;
            r_prev    <= 1'b0;
            r_drive   <= DRV_STOP;
            r_near    <= 1'b0;
            r_last    <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_counter <= n_counter;
            r_prev    <= n_prev;
            r_drive   <= n_drive;
            r_near    <= n_near;
            r_last    <= n_last;
        end
    end

    assign o_result.trigger_out     = trig;
    assign o_result.bridge_pins     = drive_pins(n_drive);
    assign o_result.last_echo_ticks = n_last;
    assign o_result.obstacle_seen   = n_near;

`ifndef NO_ASSERTIONS
    a_measure_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MEASURE |-> r_timer == '0)
        else $error("phase timer not clear during echo measurement");

    a_avoid_needs_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP || r_phase == PH_BACK || r_phase == PH_TURN) |-> r_near)
        else $error("avoidance running without an obstacle flag");

    a_measure_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase != PH_MEASURE && n_phase == PH_MEASURE) |=> r_counter == '0)
        else $error("echo counter not cleared at start of measurement");
`endif

endmodule

// ===== rtl/erob_out_buf.sv =====
// Two-entry result buffer that lets the input side run while the output is stalled.
module erob_out_buf
    import erob_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_fire;

    assign out_fire = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_accept;
            end
        end else if (i_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_accept) begin
                r_out <= i_result;
            end
        end else if (i_accept) begin
            if (r_out_valid) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register is empty");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("buffered request lost while output stalled");
`endif

endmodule

// ===== rtl/echo_ranging_obstacle_avoider.sv =====
// Top level of the echo ranging obstacle avoider: ports, configuration and result buffering.
// Each accepted request is one timer tick with the echo pin level, and the block takes
// one tick per clock cycle unless the input is stalled, returning one result per tick
// through the registered result buffer; the phase sequencer updates its state in a single
// pass between the state registers and the result register. A two-entry result buffer
// keeps input acceptance going while the output is stalled, and the input stalls only when
// both entries are full. Configuration writes should be made while no tick is in flight.
module echo_ranging_obstacle_avoider
    import erob_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_echo_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_trigger_out,
    output logic [PINS_W-1:0]    o_bridge_pins,
    output logic [REG_W-1:0]     o_last_echo_ticks,
    output logic                 o_obstacle_seen,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    in_stall;
    logic    accept;

    assign accept      = i_in_valid && !in_stall;
    assign o_cfg_ready = 1'b1;

    erob_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    erob_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_echo_level (i_echo_level),
        .i_cfg        (cfg),
        .o_result     (core_result)
    );

    erob_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_in_stall  (in_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_in_stall        = in_stall;
    assign o_trigger_out     = out_result.trigger_out;
    assign o_bridge_pins     = out_result.bridge_pins;
    assign o_last_echo_ticks = out_result.last_echo_ticks;
    assign o_obstacle_seen   = out_result.obstacle_seen;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the echo ranging obstacle avoider.
module tb_top
    import erob_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_BITS    = 24;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int TICKS_PER_PHASE = 335;

    localparam logic [REG_W-1:0] REG_ALL_ONES = {REG_W{1'b1}};
    localparam logic [REG_W-1:0] COUNT_CEILING =
        (TIMER_BITS >= REG_W) ? REG_ALL_ONES : REG_W'((64'd1 << TIMER_BITS) - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [2:0] {
        PH_TRIGGER = 3'd0,
        PH_MEASURE = 3'd1,
        PH_STOP    = 3'd2,
        PH_BACK    = 3'd3,
        PH_TURN    = 3'd4
    } t_phase;

    typedef struct packed {
        logic                 is_cfg;
        logic                 echo;
        logic [CFG_IDX_W-1:0] idx;
        logic [REG_W-1:0]     data;
        logic                 has_exp;
        t_result              exp;
    } t_row;

    localparam t_result NO_EXP = '0;

    localparam t_row DIR_ROWS [32] = '{
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b1, PINS_STOP, 24'd0, 1'b0}},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_TRIGGER_TICKS, 24'd1, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_NEAR_THRESHOLD, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_STOP_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_BACK_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_TURN_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b0, PINS_STOP, 24'd2, 1'b1}},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b0, PINS_BACKWARD, 24'd2, 1'b1}},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b0, PINS_RIGHT, 24'd2, 1'b1}},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b1, PINS_RIGHT, 24'd2, 1'b1}},
        '{1'b1, 1'b0, REG_NEAR_THRESHOLD, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b0, PINS_FORWARD, 24'd0, 1'b0}},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b0, PINS_FORWARD, 24'd2, 1'b0}},
        '{1'b1, 1'b0, REG_TRIGGER_TICKS, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_STOP_TICKS, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_BACK_TICKS, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_TURN_TICKS, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_NEAR_THRESHOLD, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_SPARE_5, 24'h5A5A5A, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_SPARE_6, 24'hA5A5A5, 1'b0, NO_EXP},
        '{1'b1, 1'b0, REG_SPARE_7, REG_ALL_ONES, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b1, '{1'b1, PINS_FORWARD, 24'd2, 1'b0}},
        '{1'b0, 1'b0, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP},
        '{1'b0, 1'b1, REG_TRIGGER_TICKS, 24'd0, 1'b0, NO_EXP}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_echo_level = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_trigger_out;
    logic [PINS_W-1:0]    o_bridge_pins;
    logic [REG_W-1:0]     o_last_echo_ticks;
    logic                 o_obstacle_seen;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data = '0;

    echo_ranging_obstacle_avoider #(
        .TIMER_BITS(TIMER_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_echo_level     (i_echo_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_trigger_out    (o_trigger_out),
        .o_bridge_pins    (o_bridge_pins),
        .o_last_echo_ticks(o_last_echo_ticks),
        .o_obstacle_seen  (o_obstacle_seen),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_cfg             regs;
    t_phase           ph;
    logic [REG_W-1:0] ph_timer;
    logic [REG_W-1:0] echo_count;
    logic [REG_W-1:0] last_count;
    logic             prev_echo;
    logic [1:0]       drive;
    logic             near;

    t_result pending_results[$];
    int      cycle_count = 0;
    int      errors = 0;
    int      ticks_sent = 0;
    int      obstacles = 0;
    int      clear_paths = 0;
    int      reg_writes = 0;
    int      stall_left = 0;
    logic    echo_run_level = 1'b0;
    int      echo_run_left = 0;

    function automatic logic calm_window();
        return ((cycle_count >> 8) % 4) == 0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_window() || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [PINS_W-1:0] pins_for(input logic [1:0] code);
        case (code)
            DRV_FORWARD:  return PINS_FORWARD;
            DRV_BACKWARD: return PINS_BACKWARD;
            DRV_RIGHT:    return PINS_RIGHT;
            default:      return PINS_STOP;
        endcase
    endfunction

    function automatic logic timer_expired(input logic [REG_W-1:0] len);
        logic [REG_W-1:0] lim;
        lim = (len == '0) ? REG_W'(1) : len;
        ph_timer = ph_timer + REG_W'(1);
        if (ph_timer >= lim) begin
            ph_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result predict_tick(input logic echo);
        t_result r;
        logic    trig;
        trig = 1'b0;
        case (ph)
            PH_MEASURE: begin
                if (prev_echo && !echo) begin
                    last_count = echo_count;
                    near = echo_count < regs.near_threshold;
                    ph_timer = '0;
                    if (near) begin
                        obstacles++;
                        ph = PH_STOP;
                    end else begin
                        clear_paths++;
                        drive = DRV_FORWARD;
                        ph = PH_TRIGGER;
                    end
                end else if (echo_count < COUNT_CEILING) begin
                    echo_count = echo_count + REG_W'(1);
                end
            end
            PH_STOP: begin
                drive = DRV_STOP;
                if (timer_expired(regs.stop_ticks)) ph = PH_BACK;
            end
            PH_BACK: begin
                drive = DRV_BACKWARD;
                if (timer_expired(regs.back_ticks)) ph = PH_TURN;
            end
            PH_TURN: begin
                drive = DRV_RIGHT;
                if (timer_expired(regs.turn_ticks)) ph = PH_TRIGGER;
            end
            default: begin
                if (ph != PH_TRIGGER) ph_timer = '0;
                ph = PH_TRIGGER;
                trig = 1'b1;
                if (timer_expired(regs.trigger_ticks)) begin
                    ph = PH_MEASURE;
                    echo_count = '0;
                end
            end
        endcase
        prev_echo = echo;
        r.trigger_out = trig;
        r.bridge_pins = pins_for(drive);
        r.last_echo_ticks = last_count;
        r.obstacle_seen = near;
        return r;
    endfunction

    // Echo pulses of random width, with single-tick glitches mixed in.
    function automatic logic next_echo();
        int r;
        if (echo_run_left == 0) begin
            echo_run_level = ~echo_run_level;
            r = $urandom_range(0, 99);
            if (r < 8) echo_run_left = 1;
            else if (r < 90) echo_run_left = $urandom_range(1, 40);
            else echo_run_left = $urandom_range(41, 120);
        end
        echo_run_left--;
        return echo_run_level;
    endfunction

    task automatic send_tick(input logic echo, input logic use_given, input t_result given);
        int      gap;
        t_result want;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_echo_level <= echo;
        do @(posedge i_clk); while (o_in_stall);
        want = predict_tick(echo);
        pending_results.push_back(use_given ? given : want);
        ticks_sent++;
    endtask

    task automatic hold_until_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TRIGGER_TICKS:  regs.trigger_ticks = val;
            REG_NEAR_THRESHOLD: regs.near_threshold = val;
            REG_STOP_TICKS:     regs.stop_ticks = val;
            REG_BACK_TICKS:     regs.back_ticks = val;
            REG_TURN_TICKS:     regs.turn_ticks = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        cycle_count++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result arrived with no tick pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_trigger_out !== want.trigger_out) begin
                    $error("trigger_out: expected %0d, got %0d", want.trigger_out,
                           o_trigger_out);
                    errors++;
                end
                if (o_bridge_pins !== want.bridge_pins) begin
                    $error("bridge_pins: expected %0d, got %0d", want.bridge_pins,
                           o_bridge_pins);
                    errors++;
                end
                if (o_last_echo_ticks !== want.last_echo_ticks) begin
                    $error("last_echo_ticks: expected %0d, got %0d", want.last_echo_ticks,
                           o_last_echo_ticks);
                    errors++;
                end
                if (o_obstacle_seen !== want.obstacle_seen) begin
                    $error("obstacle_seen: expected %0d, got %0d", want.obstacle_seen,
                           o_obstacle_seen);
                    errors++;
                end
            end
        end
        if (stall_left == 0 && !calm_window() && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(1, 3);
        end
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic cfg_open;
        regs = '{RST_TRIGGER_TICKS, RST_NEAR_THRESHOLD, RST_STOP_TICKS, RST_BACK_TICKS,
                 RST_TURN_TICKS};
        ph = PH_TRIGGER;
        ph_timer = '0;
        echo_count = '0;
        last_count = '0;
        prev_echo = 1'b0;
        drive = DRV_STOP;
        near = 1'b0;
        cfg_open = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].is_cfg) begin
                if (!cfg_open) hold_until_idle();
                cfg_open = 1'b1;
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end else begin
                if (cfg_open) i_cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_tick(DIR_ROWS[i].echo, DIR_ROWS[i].has_exp, DIR_ROWS[i].exp);
            end
        end

        // Each phase runs with its own lengths; the first three pin the extremes.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            logic [REG_W-1:0] trig_len;
            logic [REG_W-1:0] near_lvl;
            logic [REG_W-1:0] stop_len;
            logic [REG_W-1:0] back_len;
            logic [REG_W-1:0] turn_len;
            trig_len = REG_W'($urandom_range(1, 12));
            near_lvl = REG_W'($urandom_range(0, 60));
            stop_len = REG_W'($urandom_range(0, 15));
            back_len = REG_W'($urandom_range(0, 15));
            turn_len = REG_W'($urandom_range(0, 15));
            if (p == 0) begin
                trig_len = REG_W'(1);
                stop_len = '0;
                back_len = '0;
                turn_len = '0;
            end else if (p == 1) begin
                near_lvl = '0;
            end else if (p == 2) begin
                near_lvl = REG_ALL_ONES;
            end
            hold_until_idle();
            write_reg(REG_TRIGGER_TICKS, trig_len);
            write_reg(REG_NEAR_THRESHOLD, near_lvl);
            write_reg(REG_STOP_TICKS, stop_len);
            write_reg(REG_BACK_TICKS, back_len);
            write_reg(REG_TURN_TICKS, turn_len);
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_5, REG_SPARE_7)),
                      REG_W'($urandom()));
            i_cfg_valid <= 1'b0;
            for (int t = 0; t < TICKS_PER_PHASE; t++) begin
                send_tick(next_echo(), 1'b0, NO_EXP);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d ticks and %0d register writes over %0d settings.",
                 ticks_sent, reg_writes, RANDOM_PHASES + 3);
        $display("Measurements ended in %0d obstacle avoidances and %0d clear paths.",
                 obstacles, clear_paths);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
